FILE: design/bfmd_pkg.sv
// Shared types, codes and constants of the bitmap field message deframer.
package bfmd_pkg;

  localparam int FIELD_W  = 7;
  localparam int LEN_W    = 10;
  localparam int KIND_W   = 2;
  localparam int ENTRY_W  = KIND_W + LEN_W;
  localparam int HDR_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int DIGIT_W  = 2;

  localparam int DEF_FIELD_COUNT  = 128;
  localparam int DEF_BITMAP_BYTES = 16;

  localparam logic OP_TABLE = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_FIXED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PREFIX2 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PREFIX3 = 2'd2;

  localparam logic [DIGIT_W-1:0] DIGITS_SHORT = 2'd2;
  localparam logic [DIGIT_W-1:0] DIGITS_LONG  = 2'd3;

  localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] BITMAP_BIT0 = 8'h01;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_BITMAP,
    PH_PREFIX,
    PH_DATA,
    PH_DONE
  } phase_e;

  typedef enum logic {
    CTRL_RUN,
    CTRL_SCAN
  } ctrl_e;

  typedef enum logic [1:0] {
    ROLE_HEADER,
    ROLE_PREFIX,
    ROLE_DATA,
    ROLE_AFTER
  } role_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_DIGIT,
    ERR_BITMAP
  } err_e;

  typedef struct packed {
    role_e               role;
    logic [FIELD_W-1:0]  field;
    logic [LEN_W-1:0]    offset;
    logic [BYTE_W-1:0]   data;
    logic                last;
    logic [LEN_W-1:0]    len;
    logic                done;
    err_e                err;
  } res_t;

endpackage

FILE: design/bfmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfmd_ram
  import bfmd_pkg::*;
#(
  parameter int WIDTH = ENTRY_W,
  parameter int DEPTH = DEF_FIELD_COUNT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bfmd_out_buf.sv
// Two-entry result buffer between the parser and the output channel.
module bfmd_out_buf
  import bfmd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  res_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign out_data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: design/bfmd_parser.sv
// Byte parser: phase tracking, bitmap capture, prefix decode and format table scan.
module bfmd_parser
  import bfmd_pkg::*;
#(
  parameter int FIELD_COUNT  = DEF_FIELD_COUNT,
  parameter int BITMAP_BYTES = DEF_BITMAP_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [HDR_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic               start_of_message_i,
  input  logic [BYTE_W-1:0]  data_byte_i,
  input  logic [FIELD_W-1:0] format_field_i,
  input  logic [KIND_W-1:0]  format_kind_i,
  input  logic [LEN_W-1:0]   format_length_i,
  output logic               push_o,
  output res_t               push_data_o,
  input  logic               buf_full_i
);

  localparam int BM_W        = 8 * BITMAP_BYTES;
  localparam int FIELD_LIMIT = (FIELD_COUNT < BM_W) ? FIELD_COUNT : BM_W;
  localparam int CNT_W       = $clog2(FIELD_LIMIT + 1);
  localparam int AW          = $clog2(FIELD_COUNT);
  localparam int BI_W        = $clog2(BITMAP_BYTES);
  localparam int BMI_W       = $clog2(BM_W);

  // registered state
  ctrl_e              ctrl_q, ctrl_d;
  phase_e             phase_q, phase_d;
  logic [FIELD_W-1:0] cf_q, cf_d;
  logic [LEN_W-1:0]   bc_q, bc_d;
  logic [LEN_W-1:0]   acc_q, acc_d;
  logic [DIGIT_W-1:0] dc_q, dc_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [BM_W-1:0]    bitmap_q, bitmap_d;
  logic [HDR_W-1:0]   hdr_len_q;
  logic [CNT_W-1:0]   scan_f_q, scan_f_d;
  logic [CNT_W-1:0]   chk_f_q, chk_f_d;
  logic               chk_vld_q, chk_vld_d;
  res_t               pend_q;

  // byte path
  phase_e             b_ph;
  logic [FIELD_W-1:0] b_cf;
  logic [LEN_W-1:0]   b_bc;
  logic [LEN_W-1:0]   b_acc;
  logic [DIGIT_W-1:0] b_dc;
  logic [BM_W-1:0]    b_bm;
  logic [BI_W-1:0]    bm_idx;
  logic               b_need_scan;
  res_t               b_res;
  logic               is_digit;
  logic [LEN_W-1:0]   dec_acc;
  logic [DIGIT_W-1:0] dc_inc;
  logic [DIGIT_W-1:0] digits_need;

  // scan path
  logic               byte_acc;
  logic               tbl_acc;
  logic               tbl_we;
  logic               scan_issue;
  logic               scan_hit;
  logic               scan_none;
  logic [ENTRY_W-1:0] tbl_rdata;
  logic [KIND_W-1:0]  ent_kind;
  logic [LEN_W-1:0]   ent_len;
  logic               ent_usable;
  logic               present;

  assign byte_acc = in_valid_i && in_ready_o && (op_i == OP_BYTE);
  assign tbl_acc  = in_valid_i && in_ready_o && (op_i == OP_TABLE);
  assign tbl_we   = tbl_acc && (int'(format_field_i) < FIELD_COUNT);

  bfmd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FIELD_COUNT)
  ) u_fmt_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AW'(format_field_i)),
    .wdata_i ({format_kind_i, format_length_i}),
    .re_i    (scan_issue),
    .raddr_i (AW'(scan_f_q)),
    .rdata_o (tbl_rdata)
  );

  assign is_digit    = (data_byte_i >= ASCII_ZERO) && (data_byte_i <= ASCII_NINE);
  assign dec_acc     = LEN_W'({acc_q, 3'b000} + {2'b00, acc_q, 1'b0}
                              + 13'(data_byte_i[3:0]));
  assign dc_inc      = dc_q + DIGIT_W'(1);
  assign digits_need = (kind_q == KIND_PREFIX3) ? DIGITS_LONG : DIGITS_SHORT;

  always_comb begin : byte_path
    b_ph        = phase_q;
    b_cf        = cf_q;
    b_bc        = bc_q;
    b_acc       = acc_q;
    b_dc        = dc_q;
    b_bm        = bitmap_q;
    bm_idx      = '0;
    b_need_scan = 1'b0;
    b_res       = '0;
    b_res.role  = ROLE_AFTER;
    b_res.err   = ERR_NONE;
    b_res.data  = data_byte_i;

    if (start_of_message_i) begin
      b_ph  = PH_HEADER;
      b_cf  = '0;
      b_bc  = '0;
      b_acc = '0;
      b_dc  = '0;
      b_bm  = '0;
    end

    if (b_ph == PH_HEADER && b_bc >= LEN_W'(hdr_len_q)) begin
      b_ph = PH_BITMAP;
      b_bc = '0;
    end

    unique case (b_ph)
      PH_HEADER: begin
        b_res.role   = ROLE_HEADER;
        b_res.offset = b_bc;
        b_bc         = b_bc + LEN_W'(1);
      end
      PH_BITMAP: begin
        bm_idx       = b_bc[BI_W-1:0];
        b_res.role   = ROLE_DATA;
        b_res.offset = LEN_W'(bm_idx);
        b_res.len    = LEN_W'(BITMAP_BYTES);
        b_bm[{bm_idx, 3'b000} +: 8] = b_bm[{bm_idx, 3'b000} +: 8] | data_byte_i;
        if (bm_idx == '0 && (data_byte_i & BITMAP_BIT0) == '0) begin
          // field 0 must be flagged present: abandon the message
          b_res.err = ERR_BITMAP;
          b_ph      = PH_DONE;
        end else begin
          b_bc = LEN_W'(bm_idx) + LEN_W'(1);
          if (b_bc >= LEN_W'(BITMAP_BYTES)) begin
            b_res.last  = 1'b1;
            b_cf        = '0;
            b_need_scan = 1'b1;
          end
        end
      end
      PH_PREFIX: begin
        b_res.role   = ROLE_PREFIX;
        b_res.field  = b_cf;
        b_res.offset = LEN_W'(b_dc);
        if (!is_digit) begin
          b_res.err = ERR_DIGIT;
          b_res.len = b_acc;
          b_ph      = PH_DONE;
        end else begin
          b_acc     = dec_acc;
          b_res.len = dec_acc;
          b_dc      = dc_inc;
          if (dc_inc >= digits_need) begin
            if (dec_acc == '0) begin
              b_need_scan = 1'b1;
            end else begin
              b_ph = PH_DATA;
              b_bc = '0;
            end
          end
        end
      end
      PH_DATA: begin
        b_res.role   = ROLE_DATA;
        b_res.field  = b_cf;
        b_res.offset = b_bc;
        b_res.len    = b_acc;
        b_bc         = b_bc + LEN_W'(1);
        if (b_bc >= b_acc) begin
          b_res.last  = 1'b1;
          b_need_scan = 1'b1;
        end
      end
      default: begin
        b_ph = PH_DONE;
      end
    endcase
  end

  // scan: issue one table read per cycle, check the entry in the cycle after its read
  assign ent_kind   = tbl_rdata[ENTRY_W-1 -: KIND_W];
  assign ent_len    = tbl_rdata[LEN_W-1:0];
  assign present    = bitmap_q[BMI_W'(chk_f_q)];
  assign ent_usable = (ent_kind == KIND_PREFIX2) || (ent_kind == KIND_PREFIX3)
                      || (ent_kind == KIND_FIXED && ent_len != '0);
  assign scan_issue = (ctrl_q == CTRL_SCAN) && (scan_f_q < CNT_W'(FIELD_LIMIT));
  assign scan_hit   = (ctrl_q == CTRL_SCAN) && chk_vld_q && present && ent_usable;
  assign scan_none  = (ctrl_q == CTRL_SCAN) && !scan_hit && !scan_issue;

  always_comb begin : ctrl_next
    ctrl_d = ctrl_q;
    unique case (ctrl_q)
      CTRL_RUN: begin
        if (byte_acc && b_need_scan) begin
          ctrl_d = CTRL_SCAN;
        end
      end
      CTRL_SCAN: begin
        if (scan_hit || scan_none) begin
          ctrl_d = CTRL_RUN;
        end
      end
      default: begin
        ctrl_d = CTRL_RUN;
      end
    endcase
  end

  always_comb begin : ctrl_out
    in_ready_o  = (ctrl_q == CTRL_RUN) && !buf_full_i;
    push_o      = 1'b0;
    push_data_o = b_res;
    if (ctrl_q == CTRL_SCAN) begin
      push_o           = scan_hit || scan_none;
      push_data_o      = pend_q;
      push_data_o.done = scan_none;
    end else begin
      push_o = byte_acc && !b_need_scan;
    end
  end

  always_comb begin : state_next
    phase_d   = phase_q;
    cf_d      = cf_q;
    bc_d      = bc_q;
    acc_d     = acc_q;
    dc_d      = dc_q;
    kind_d    = kind_q;
    bitmap_d  = bitmap_q;
    scan_f_d  = scan_f_q;
    chk_f_d   = chk_f_q;
    chk_vld_d = 1'b0;

    if (byte_acc) begin
      phase_d  = b_ph;
      cf_d     = b_cf;
      bc_d     = b_bc;
      acc_d    = b_acc;
      dc_d     = b_dc;
      bitmap_d = b_bm;
      if (b_need_scan) begin
        scan_f_d = CNT_W'({1'b0, b_cf}) + CNT_W'(1);
      end
    end

    // follow a rewrite of the open field's entry: the digit count uses its kind
    if (tbl_we && format_field_i == cf_q) begin
      kind_d = format_kind_i;
    end

    if (scan_issue) begin
      scan_f_d  = scan_f_q + CNT_W'(1);
      chk_f_d   = scan_f_q;
      chk_vld_d = !scan_hit;
    end

    if (scan_hit) begin
      // open the field found
      cf_d   = FIELD_W'(chk_f_q);
      bc_d   = '0;
      dc_d   = '0;
      kind_d = ent_kind;
      if (ent_kind == KIND_FIXED) begin
        phase_d = PH_DATA;
        acc_d   = ent_len;
      end else begin
        phase_d = PH_PREFIX;
        acc_d   = '0;
      end
    end else if (scan_none) begin
      phase_d = PH_DONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_acc && b_need_scan) begin
      pend_q <= b_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q    <= CTRL_RUN;
      phase_q   <= PH_HEADER;
      cf_q      <= '0;
      bc_q      <= '0;
      acc_q     <= '0;
      dc_q      <= '0;
      kind_q    <= KIND_FIXED;
      bitmap_q  <= '0;
      hdr_len_q <= '0;
      scan_f_q  <= '0;
      chk_f_q   <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      ctrl_q    <= ctrl_d;
      phase_q   <= phase_d;
      cf_q      <= cf_d;
      bc_q      <= bc_d;
      acc_q     <= acc_d;
      dc_q      <= dc_d;
      kind_q    <= kind_d;
      bitmap_q  <= bitmap_d;
      scan_f_q  <= scan_f_d;
      chk_f_q   <= chk_f_d;
      chk_vld_q <= chk_vld_d;
      if (cfg_we_i) begin
        hdr_len_q <= cfg_wdata_i;
      end
    end
  end

endmodule

FILE: design/bitmap_field_message_deframer.sv
// Top level of the bitmap field message deframer.
//
// Input channel (in_valid_i / in_ready_o): a beat with op_i = 0 writes one
// format table entry and yields no result; a beat with op_i = 1 carries one
// message byte, start_of_message_i marking the first byte of a message.
// Output channel (out_valid_o / out_ready_i): one result beat per message byte,
// tagging the byte with role, field, offset, length, last, done and error.
// Throughput: one beat per cycle for table writes and for bytes that do not
// end a field. A byte that ends a field (last bitmap byte, last data byte,
// last digit of a zero length prefix) starts a walk of the format table RAM,
// one field number per cycle from the next field upward, reading field numbers
// up to the next present, non-empty field and none at or above
// min(FIELD_COUNT, 8 * BITMAP_BYTES). Input is held off during the walk.
// Latency: a result is valid the cycle after its byte is accepted, or the
// cycle after the table walk ends.
// Stall: up to two results are buffered; in_ready_o drops when both wait.
// Reset: parsing starts in the header phase, header_length is 0, the bitmap
// is clear; format table entries hold nothing valid until written.
module bitmap_field_message_deframer
  import bfmd_pkg::*;
#(
  parameter int FIELD_COUNT  = DEF_FIELD_COUNT,
  parameter int BITMAP_BYTES = DEF_BITMAP_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [HDR_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic               start_of_message_i,
  input  logic [BYTE_W-1:0]  data_byte_i,
  input  logic [FIELD_W-1:0] format_field_i,
  input  logic [KIND_W-1:0]  format_kind_i,
  input  logic [LEN_W-1:0]   format_length_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         byte_role_o,
  output logic [FIELD_W-1:0] field_index_o,
  output logic [LEN_W-1:0]   byte_offset_o,
  output logic [BYTE_W-1:0]  out_byte_o,
  output logic               field_last_o,
  output logic [LEN_W-1:0]   field_length_o,
  output logic               message_done_o,
  output logic [1:0]         error_code_o
);

  logic push;
  res_t push_data;
  logic buf_full;
  res_t out_res;

  bfmd_parser #(
    .FIELD_COUNT  (FIELD_COUNT),
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_parser (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .start_of_message_i (start_of_message_i),
    .data_byte_i        (data_byte_i),
    .format_field_i     (format_field_i),
    .format_kind_i      (format_kind_i),
    .format_length_i    (format_length_i),
    .push_o             (push),
    .push_data_o        (push_data),
    .buf_full_i         (buf_full)
  );

  bfmd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign byte_role_o    = out_res.role;
  assign field_index_o  = out_res.field;
  assign byte_offset_o  = out_res.offset;
  assign out_byte_o     = out_res.data;
  assign field_last_o   = out_res.last;
  assign field_length_o = out_res.len;
  assign message_done_o = out_res.done;
  assign error_code_o   = out_res.err;

endmodule

FILE: design/bfmd_checker.sv
// Port-level checks of the deframer's result beats, bound to the top level.
module bfmd_checker
  import bfmd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [1:0]         byte_role_i,
  input logic [FIELD_W-1:0] field_index_i,
  input logic [LEN_W-1:0]   byte_offset_i,
  input logic               field_last_i,
  input logic [LEN_W-1:0]   field_length_i,
  input logic               message_done_i,
  input logic [1:0]         error_code_i
);

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_offset_i)
      && $stable(byte_role_i) && $stable(field_length_i))
    else $error("stalled result beat changed or dropped");

  a_after_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && byte_role_i == ROLE_AFTER |-> field_index_i == '0
      && byte_offset_i == '0 && field_length_i == '0 && !field_last_i
      && !message_done_i && error_code_i == ERR_NONE)
    else $error("byte after message end carries field information");

  a_error_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_code_i != ERR_NONE |-> !field_last_i && !message_done_i)
    else $error("error beat also marks a field or message end");

  a_done_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && message_done_i |-> field_last_i || byte_role_i == ROLE_PREFIX)
    else $error("message done without a field end");

  a_last_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && field_last_i |-> (byte_offset_i + LEN_W'(1)) == field_length_i)
    else $error("last beat of a field at the wrong offset");

endmodule

bind bitmap_field_message_deframer bfmd_checker u_bfmd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .byte_role_i    (byte_role_o),
  .field_index_i  (field_index_o),
  .byte_offset_i  (byte_offset_o),
  .field_last_i   (field_last_o),
  .field_length_i (field_length_o),
  .message_done_i (message_done_o),
  .error_code_i   (error_code_o)
);

FILE: sim/bitmap_field_message_deframer_tb.sv
// Self-checking testbench: random framed messages against a cycle-free deframer model.
`timescale 1ns / 1ps

module bitmap_field_message_deframer_tb;
  import bfmd_pkg::*;

  localparam int FIELD_COUNT  = DEF_FIELD_COUNT;
  localparam int BITMAP_BYTES = DEF_BITMAP_BYTES;
  localparam int WALK_CYCLES  = FIELD_COUNT + 8;
  localparam logic [KIND_W-1:0] KIND_ABSENT = 2'd3;

  typedef struct packed {
    logic               op;
    logic               som;
    logic [BYTE_W-1:0]  data;
    logic [FIELD_W-1:0] fld;
    logic [KIND_W-1:0]  kind;
    logic [LEN_W-1:0]   len;
  } beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [HDR_W-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               op_i = 1'b0;
  logic               start_of_message_i = 1'b0;
  logic [BYTE_W-1:0]  data_byte_i = '0;
  logic [FIELD_W-1:0] format_field_i = '0;
  logic [KIND_W-1:0]  format_kind_i = '0;
  logic [LEN_W-1:0]   format_length_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         byte_role_o;
  logic [FIELD_W-1:0] field_index_o;
  logic [LEN_W-1:0]   byte_offset_o;
  logic [BYTE_W-1:0]  out_byte_o;
  logic               field_last_o;
  logic [LEN_W-1:0]   field_length_o;
  logic               message_done_o;
  logic [1:0]         error_code_o;

  bitmap_field_message_deframer dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .start_of_message_i (start_of_message_i),
    .data_byte_i        (data_byte_i),
    .format_field_i     (format_field_i),
    .format_kind_i      (format_kind_i),
    .format_length_i    (format_length_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .byte_role_o        (byte_role_o),
    .field_index_o      (field_index_o),
    .byte_offset_o      (byte_offset_o),
    .out_byte_o         (out_byte_o),
    .field_last_o       (field_last_o),
    .field_length_o     (field_length_o),
    .message_done_o     (message_done_o),
    .error_code_o       (error_code_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Deframer state as the checker sees it
  logic [KIND_W-1:0]  tbl_kind [FIELD_COUNT];
  logic [LEN_W-1:0]   tbl_len [FIELD_COUNT];
  logic [127:0]       present_map = '0;
  phase_e             phase = PH_HEADER;
  logic [FIELD_W-1:0] cur_field = '0;
  logic [LEN_W-1:0]   byte_cnt = '0;
  logic [LEN_W-1:0]   len_acc = '0;
  logic [DIGIT_W-1:0] digit_cnt = '0;
  logic [HDR_W-1:0]   hdr_len = '0;

  // Table and header length as the stimulus generator plans them
  logic [KIND_W-1:0]  plan_kind [FIELD_COUNT];
  logic [LEN_W-1:0]   plan_len [FIELD_COUNT];
  logic [HDR_W-1:0]   plan_hdr = '0;

  beat_t send_q [$];
  res_t  tag_q [$];
  beat_t offer;
  res_t  head_tag;
  bit    offering = 1'b0;
  bit    beat_taken = 1'b0;
  bit    calm = 1'b0;
  bit    hold_req = 1'b0;
  int    send_gap = 0;
  int    ready_gap = 0;
  int    hold_cycles = 0;
  int    fail_count = 0;
  int    bytes_sent = 0;
  int    messages_sent = 0;
  int    n_checked = 0;
  int    n_done = 0;
  int    n_digit_err = 0;
  int    n_bitmap_err = 0;

  // Open the next present, non-empty field; return 1 when the message is complete.
  function automatic bit advance_field();
    for (int f = int'(cur_field) + 1; f < FIELD_COUNT; f++) begin
      if (!present_map[f]) continue;
      if (tbl_kind[f] == KIND_PREFIX2 || tbl_kind[f] == KIND_PREFIX3 ||
          (tbl_kind[f] == KIND_FIXED && tbl_len[f] != '0)) begin
        cur_field = FIELD_W'(f);
        byte_cnt  = '0;
        digit_cnt = '0;
        if (tbl_kind[f] == KIND_FIXED) begin
          phase   = PH_DATA;
          len_acc = tbl_len[f];
        end else begin
          phase   = PH_PREFIX;
          len_acc = '0;
        end
        return 1'b0;
      end
    end
    phase = PH_DONE;
    return 1'b1;
  endfunction

  function automatic void tag_byte(beat_t b);
    res_t               r;
    int unsigned        acc;
    logic [3:0]         idx;
    logic [DIGIT_W-1:0] need;
    if (b.op == OP_TABLE) begin
      tbl_kind[b.fld] = b.kind;
      tbl_len[b.fld]  = b.len;
      return;
    end
    r      = '0;
    r.role = ROLE_AFTER;
    r.err  = ERR_NONE;
    r.data = b.data;
    if (b.som) begin
      present_map = '0;
      phase       = PH_HEADER;
      cur_field   = '0;
      byte_cnt    = '0;
      len_acc     = '0;
      digit_cnt   = '0;
    end
    if (phase == PH_HEADER && byte_cnt >= LEN_W'(hdr_len)) begin
      phase    = PH_BITMAP;
      byte_cnt = '0;
    end
    case (phase)
      PH_HEADER: begin
        r.role   = ROLE_HEADER;
        r.offset = byte_cnt;
        byte_cnt = byte_cnt + LEN_W'(1);
      end
      PH_BITMAP: begin
        idx      = byte_cnt[3:0];
        r.role   = ROLE_DATA;
        r.offset = LEN_W'(idx);
        r.len    = LEN_W'(BITMAP_BYTES);
        present_map[int'(idx) * 8 +: 8] |= b.data;
        if (idx == '0 && (b.data & BITMAP_BIT0) == '0) begin
          r.err = ERR_BITMAP;
          phase = PH_DONE;
        end else begin
          byte_cnt = LEN_W'(idx) + LEN_W'(1);
          if (byte_cnt >= LEN_W'(BITMAP_BYTES)) begin
            r.last    = 1'b1;
            cur_field = '0;
            r.done    = advance_field();
          end
        end
      end
      PH_PREFIX: begin
        need     = (tbl_kind[cur_field] == KIND_PREFIX3) ? DIGITS_LONG : DIGITS_SHORT;
        r.role   = ROLE_PREFIX;
        r.field  = cur_field;
        r.offset = LEN_W'(digit_cnt);
        if (b.data < ASCII_ZERO || b.data > ASCII_NINE) begin
          r.err = ERR_DIGIT;
          r.len = len_acc;
          phase = PH_DONE;
        end else begin
          acc       = len_acc * 10 + (b.data - ASCII_ZERO);
          len_acc   = acc[LEN_W-1:0];
          r.len     = len_acc;
          digit_cnt = digit_cnt + DIGIT_W'(1);
          if (digit_cnt >= need) begin
            if (len_acc == '0) begin
              r.done = advance_field();
            end else begin
              phase    = PH_DATA;
              byte_cnt = '0;
            end
          end
        end
      end
      PH_DATA: begin
        r.role   = ROLE_DATA;
        r.field  = cur_field;
        r.offset = byte_cnt;
        r.len    = len_acc;
        byte_cnt = byte_cnt + LEN_W'(1);
        if (byte_cnt >= len_acc) begin
          r.last = 1'b1;
          r.done = advance_field();
        end
      end
      default: phase = PH_DONE;
    endcase
    tag_q.push_back(r);
  endfunction

  task automatic put_entry(int f, logic [KIND_W-1:0] k, logic [LEN_W-1:0] l);
    beat_t b;
    b.op   = OP_TABLE;
    b.som  = 1'($urandom_range(0, 1));
    b.data = BYTE_W'($urandom_range(0, 255));
    b.fld  = FIELD_W'(f);
    b.kind = k;
    b.len  = l;
    plan_kind[f] = k;
    plan_len[f]  = l;
    send_q.push_back(b);
  endtask

  task automatic put_random_entry(int f);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) put_entry(f, KIND_FIXED, LEN_W'($urandom_range(0, 6)));
    else if (pick < 7) put_entry(f, KIND_PREFIX2, LEN_W'($urandom_range(0, 1023)));
    else if (pick < 9) put_entry(f, KIND_PREFIX3, LEN_W'($urandom_range(0, 1023)));
    else put_entry(f, KIND_ABSENT, LEN_W'($urandom_range(0, 1023)));
  endtask

  task automatic put_byte(logic som, logic [BYTE_W-1:0] d);
    beat_t b;
    b.op   = OP_BYTE;
    b.som  = som;
    b.data = d;
    b.fld  = FIELD_W'($urandom_range(0, 127));
    b.kind = KIND_W'($urandom_range(0, 3));
    b.len  = LEN_W'($urandom_range(0, 1023));
    send_q.push_back(b);
    bytes_sent++;
  endtask

  function automatic logic [127:0] random_presence();
    logic [127:0] m;
    m = '0;
    if ($urandom_range(0, 11) == 0) begin
      for (int i = 0; i < 4; i++) m[i*32 +: 32] = $urandom() & $urandom() & $urandom();
    end else begin
      repeat ($urandom_range(0, 5)) m[$urandom_range(1, FIELD_COUNT - 1)] = 1'b1;
    end
    m[0] = ($urandom_range(0, 19) != 0);
    return m;
  endfunction

  // Build one message from the planned table; some get a bad digit, a cut or trailing bytes.
  task automatic put_message(logic [127:0] presence);
    logic [BYTE_W-1:0] msg [$];
    logic [BYTE_W-1:0] digs [3];
    int                len;
    int                body;
    int                ndig;
    int                bad;
    int                cut;
    bit                abandon;
    abandon = 1'b0;
    repeat (plan_hdr) msg.push_back(BYTE_W'($urandom_range(0, 255)));
    for (int i = 0; i < BITMAP_BYTES; i++) msg.push_back(presence[i*8 +: 8]);
    for (int f = 1; f < FIELD_COUNT && presence[0] && !abandon; f++) begin
      if (!presence[f] || plan_kind[f] == KIND_ABSENT) continue;
      body = int'(plan_len[f]);
      if (plan_kind[f] != KIND_FIXED) begin
        if ($urandom_range(0, 15) == 0)
          len = $urandom_range(0, (plan_kind[f] == KIND_PREFIX3) ? 999 : 99);
        else
          len = $urandom_range(0, 10);
        if (plan_kind[f] == KIND_PREFIX3) begin
          ndig    = 3;
          digs[0] = BYTE_W'(ASCII_ZERO + len / 100);
          digs[1] = BYTE_W'(ASCII_ZERO + (len / 10) % 10);
          digs[2] = BYTE_W'(ASCII_ZERO + len % 10);
        end else begin
          ndig    = 2;
          digs[0] = BYTE_W'(ASCII_ZERO + len / 10);
          digs[1] = BYTE_W'(ASCII_ZERO + len % 10);
        end
        bad  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, ndig - 1) : -1;
        body = len;
        for (int i = 0; i < ndig; i++) begin
          if (i == bad) begin
            msg.push_back(BYTE_W'($urandom_range(0, 1) ? $urandom_range(0, 8'h2F)
                                                        : $urandom_range(8'h3A, 8'hFF)));
            abandon = 1'b1;
            body    = 0;
            break;
          end
          msg.push_back(digs[i]);
        end
        // long prefixed fields: send the digits and a few bytes, then cut the message
        if (len > 24) begin
          body    = $urandom_range(0, 3);
          abandon = 1'b1;
        end
      end
      repeat (body) msg.push_back(BYTE_W'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, msg.size() - 1);
      while (msg.size() > cut) void'(msg.pop_back());
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) msg.push_back(BYTE_W'($urandom_range(0, 255)));
    foreach (msg[i]) begin
      if (i != 0 && $urandom_range(0, 63) == 0)
        put_entry(0, KIND_W'($urandom_range(0, 3)), LEN_W'($urandom_range(0, 1023)));
      put_byte(i == 0, msg[i]);
    end
    messages_sent++;
  endtask

  task automatic run_messages(int quota);
    int first;
    first = bytes_sent;
    while (bytes_sent - first < quota) begin
      if ($urandom_range(0, 11) == 0)
        repeat ($urandom_range(1, 4)) put_random_entry($urandom_range(1, FIELD_COUNT - 1));
      else
        put_message(random_presence());
    end
  endtask

  // Wait for the stream to drain and any trailing table walk to finish.
  task automatic settle();
    while (send_q.size() != 0 || offering || tag_q.size() != 0) @(negedge clk_i);
    repeat (WALK_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_header_length(logic [HDR_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    hdr_len  = v;
    plan_hdr = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_field(string name, logic [LEN_W-1:0] want, logic [LEN_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Input beats: predict at the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      tag_byte(offer);
      beat_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (beat_taken) begin
      beat_taken = 1'b0;
      offering   = 1'b0;
      if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
    end
    if (!offering) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (send_q.size() > 0) begin
        offer = send_q.pop_front();
        op_i               <= offer.op;
        start_of_message_i <= offer.som;
        data_byte_i        <= offer.data;
        format_field_i     <= offer.fld;
        format_kind_i      <= offer.kind;
        format_length_i    <= offer.len;
        in_valid_i         <= 1'b1;
        offering = 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side: random stall bursts plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req    = 1'b0;
      hold_cycles = 80;
      out_ready_i <= 1'b0;
    end else if (calm) begin
      out_ready_i <= 1'b1;
    end else if (ready_gap > 0) begin
      ready_gap--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      ready_gap = $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tag_q.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, actual byte %0d role %0d",
                 $time, out_byte_o, byte_role_o);
        fail_count++;
      end else begin
        head_tag = tag_q.pop_front();
        check_field("byte_role", LEN_W'(head_tag.role), LEN_W'(byte_role_o));
        check_field("field_index", LEN_W'(head_tag.field), LEN_W'(field_index_o));
        check_field("byte_offset", head_tag.offset, byte_offset_o);
        check_field("out_byte", LEN_W'(head_tag.data), LEN_W'(out_byte_o));
        check_field("field_last", LEN_W'(head_tag.last), LEN_W'(field_last_o));
        check_field("field_length", head_tag.len, field_length_o);
        check_field("message_done", LEN_W'(head_tag.done), LEN_W'(message_done_o));
        check_field("error_code", LEN_W'(head_tag.err), LEN_W'(error_code_o));
        n_checked++;
        if (head_tag.done) n_done++;
        if (head_tag.err == ERR_DIGIT) n_digit_err++;
        if (head_tag.err == ERR_BITMAP) n_bitmap_err++;
      end
    end
  end

  initial begin
    #15_000_000;
    $display("** bitmap_field_message_deframer: FAILED **");
    $finish;
  end

  initial begin
    logic [127:0] special;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int f = 0; f < FIELD_COUNT; f++) put_random_entry(f);
    // absent kind, empty fixed field, zero-length prefix that ends the message
    put_entry(1, KIND_ABSENT, 10'h3FF);
    put_entry(2, KIND_FIXED, 10'd0);
    put_entry(3, KIND_PREFIX2, 10'h155);
    for (int i = 0; i < BITMAP_BYTES; i++) put_byte(i == 0, (i == 0) ? 8'h0F : 8'h00);
    put_byte(1'b0, ASCII_ZERO);
    put_byte(1'b0, ASCII_ZERO);
    put_byte(1'b0, 8'hFF);
    // bitmap bit 0 clear, then a byte after the abandoned message
    put_byte(1'b1, 8'hFE);
    put_byte(1'b0, 8'h00);
    messages_sent += 2;
    settle();

    set_header_length(6'd63);
    run_messages(100);
    settle();

    set_header_length(6'd1);
    run_messages(100);
    hold_req = 1'b1;
    settle();

    set_header_length(6'd0);
    for (int f = 1; f < FIELD_COUNT; f++) put_random_entry(f);
    special = '0;
    special[0] = 1'b1;
    special[FIELD_COUNT-1] = 1'b1;
    // fixed length above 999 on the top field, message cut after 24 data bytes
    put_entry(FIELD_COUNT - 1, KIND_FIXED, 10'h3FF);
    for (int i = 0; i < BITMAP_BYTES; i++) put_byte(i == 0, special[i*8 +: 8]);
    repeat (24) put_byte(1'b0, BYTE_W'($urandom_range(0, 255)));
    messages_sent++;
    put_entry(FIELD_COUNT - 1, KIND_FIXED, 10'd2);
    run_messages(100);
    settle();

    set_header_length(HDR_W'($urandom_range(2, 12)));
    run_messages(120);
    settle();

    calm = 1'b1;
    set_header_length(HDR_W'($urandom_range(0, 63)));
    run_messages(100);
    settle();

    $display("Checked %0d result beats from %0d bytes in %0d messages over five header lengths.",
             n_checked, bytes_sent, messages_sent);
    $display("Seen: %0d completed messages, %0d bad length digits, %0d bitmap errors.",
             n_done, n_digit_err, n_bitmap_err);
    if (fail_count == 0) begin
      $display("** bitmap_field_message_deframer: PASSED **");
    end else begin
      $display("** bitmap_field_message_deframer: FAILED **");
    end
    $finish;
  end

endmodule
